// ===== src/v3o_pkg.sv =====
// ----------------------------------------------------------------------------
// v3o_pkg: shared types and constants of the 3D vector unit
// Transaction payloads, operation codes, pipeline stage map, CORDIC table.
// ----------------------------------------------------------------------------
package v3o_pkg;

	typedef enum logic [1:0] {
		OP_NORM   = 2'd0,
		OP_OFFSET = 2'd1,
		OP_CROSS  = 2'd2,
		OP_ANGLE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic [17:0]        angle;
		logic               overflow;
	} rsp_t;

	// classified transaction held between front and back
	typedef struct packed {
		op_t                op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} item_t;

	// front queue
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// arithmetic units
	localparam int SQ_STAGES    = 32;
	localparam int SQ_REM_W     = 35;
	localparam int DIV_NUM_W    = 49;
	localparam int DIV_QUO_W    = 17;
	localparam int DIV_STAGES   = DIV_QUO_W;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 34;

	// normalize lane stage map (stage 0 is the back input register)
	localparam int NRM_SQ_IN   = 4;
	localparam int NRM_SQ_OUT  = NRM_SQ_IN + SQ_STAGES;
	localparam int NRM_DIV_IN  = NRM_SQ_OUT + 1;
	localparam int NRM_DIV_OUT = NRM_DIV_IN + DIV_STAGES;
	localparam int NORM_LAT    = NRM_DIV_OUT + 1;

	// angle path stage map
	localparam int ANG_DOT   = NORM_LAT + 1;
	localparam int ANG_SUM   = ANG_DOT + 1;
	localparam int ANG_CLS   = ANG_SUM + 1;
	localparam int ANG_ARG   = ANG_CLS + 1;
	localparam int ANG_SQRT  = ANG_ARG + SQ_STAGES;
	localparam int ANG_CORD  = ANG_SQRT + CORDIC_STEPS;
	localparam int LAST      = ANG_CORD + 1;

	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic [17:0]        PI_Q16 = 18'd205887;

	// arctan(2^-i) in units of 2^-30, rounded
	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

endpackage

// ===== src/v3o_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3o_sqrt: pipelined integer square root
// floor(sqrt(rad)) for a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module v3o_sqrt import v3o_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [SQ_REM_W-1:0] rem_q  [SQ_STAGES];
	logic [31:0]         root_q [SQ_STAGES];
	logic [63:0]         rad_q  [SQ_STAGES];

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
		localparam int P = SQ_STAGES - 1 - j;
		logic [SQ_REM_W-1:0] rem_in, cur, trial;
		logic [31:0]         root_in;
		logic [63:0]         rad_in;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign rad_in  = rad_q[j-1];
		end

		assign cur   = {rem_in[SQ_REM_W-3:0], rad_in[2*P+1 -: 2]};
		assign trial = SQ_REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_q[j]  <= cur - trial;
					root_q[j] <= {root_in[30:0], 1'b1};
				end else begin
					rem_q[j]  <= cur;
					root_q[j] <= {root_in[30:0], 1'b0};
				end
				rad_q[j] <= rad_in;
			end
		end
	end

	assign root = root_q[SQ_STAGES-1];

endmodule

// ===== src/v3o_div.sv =====
// ----------------------------------------------------------------------------
// v3o_div: pipelined restoring divider
// Quotient known to fit DIV_QUO_W bits; one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3o_div import v3o_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [31:0]          den,
	output logic [DIV_QUO_W-1:0] quo
);

	logic [DIV_NUM_W-1:0] rem_q [DIV_STAGES];
	logic [31:0]          den_q [DIV_STAGES];
	logic [DIV_QUO_W-1:0] quo_q [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int B = DIV_QUO_W - 1 - j;
		logic [DIV_NUM_W-1:0] rem_in, trial;
		logic [31:0]          den_in;
		logic [DIV_QUO_W-1:0] quo_in;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign den_in = den_q[j-1];
			assign quo_in = quo_q[j-1];
		end

		assign trial = DIV_NUM_W'(den_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[j] <= rem_in - trial;
					quo_q[j] <= quo_in | (DIV_QUO_W'(1) << B);
				end else begin
					rem_q[j] <= rem_in;
					quo_q[j] <= quo_in;
				end
				den_q[j] <= den_in;
			end
		end
	end

	assign quo = quo_q[DIV_STAGES-1];

endmodule

// ===== src/v3o_cordic.sv =====
// ----------------------------------------------------------------------------
// v3o_cordic: pipelined CORDIC in vectoring mode
// Returns the accumulated angle of (x0, y0) in units of 2^-30.
// ----------------------------------------------------------------------------
module v3o_cordic import v3o_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic [29:0]                x0,
	input  logic [31:0]                y0,
	output logic signed [CORDIC_W-1:0] z
);

	logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CORDIC_W-1:0] x_in, y_in, z_in, dx, dy, at;

		if (i == 0) begin : g_first
			assign x_in = CORDIC_W'(x0);
			assign y_in = CORDIC_W'(y0);
			assign z_in = '0;
		end else begin : g_next
			assign x_in = x_q[i-1];
			assign y_in = y_q[i-1];
			assign z_in = z_q[i-1];
		end

		// arithmetic shifts are floor divisions
		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = CORDIC_W'(ATAN_TAB[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_in > 0) begin
					x_q[i] <= x_in + dx;
					y_q[i] <= y_in - dy;
					z_q[i] <= z_in + at;
				end else begin
					x_q[i] <= x_in - dx;
					y_q[i] <= y_in + dy;
					z_q[i] <= z_in - at;
				end
			end
		end
	end

	assign z = z_q[CORDIC_STEPS-1];

endmodule

// ===== src/v3o_norm.sv =====
// ----------------------------------------------------------------------------
// v3o_norm: unit vector lane
// Squares, sum, even pre-shift, square root and three dividers; the result
// is each component over the length in signed Q1.16, truncated toward zero.
// ----------------------------------------------------------------------------
module v3o_norm import v3o_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][31:0] vec,
	output logic [2:0][17:0] unit,
	output logic             zero
);

	logic [2:0][31:0] mag;
	logic [63:0]      sq_s1 [3];
	logic [63:0]      s_s2, s_s3, s_s4;
	logic [4:0]       k_s3;
	logic             done_s3;
	logic [63:0]      sh3, sh4;
	logic [4:0]       k3, k4;
	logic             done3;

	logic [2:0][31:0] mag_d  [1:NRM_SQ_OUT];
	logic [2:0]       neg_d  [1:NRM_SQ_OUT];
	logic             zero_d [1:NRM_SQ_OUT];
	logic [4:0]       k_d    [NRM_SQ_IN:NRM_SQ_OUT];

	logic [31:0]          len;
	logic [31:0]          len_s37;
	logic [DIV_NUM_W-1:0] num_s37 [3];
	logic [DIV_QUO_W-1:0] quo [3];
	logic [3:0]           nz_d [NRM_DIV_IN:NRM_DIV_OUT];

	for (genvar i = 0; i < 3; i++) begin : g_mag
		assign mag[i] = vec[i][31] ? 32'(-vec[i]) : vec[i];
	end

	// coarse pre-shift: 16 pairs (cap) or 8 pairs
	always_comb begin
		sh3   = s_s2;
		k3    = '0;
		done3 = 1'b0;
		if (s_s2[63:32] == '0) begin
			sh3   = {s_s2[31:0], 32'd0};
			k3    = 5'd16;
			done3 = 1'b1;
		end else if (s_s2[63:48] == '0) begin
			sh3 = {s_s2[47:0], 16'd0};
			k3  = 5'd8;
		end
	end

	// fine pre-shift: 4, 2, 1 pairs
	always_comb begin
		sh4 = s_s3;
		k4  = k_s3;
		if (!done_s3) begin
			if (sh4[63:56] == '0) begin
				sh4 = {sh4[55:0], 8'd0};
				k4  = k4 + 5'd4;
			end
			if (sh4[63:60] == '0) begin
				sh4 = {sh4[59:0], 4'd0};
				k4  = k4 + 5'd2;
			end
			if (sh4[63:62] == '0) begin
				sh4 = {sh4[61:0], 2'd0};
				k4  = k4 + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= mag[i] * mag[i];
			end
			mag_d[1]  <= mag;
			neg_d[1]  <= {vec[2][31], vec[1][31], vec[0][31]};
			zero_d[1] <= (vec == '0);
			for (int j = 2; j <= NRM_SQ_OUT; j++) begin
				mag_d[j]  <= mag_d[j-1];
				neg_d[j]  <= neg_d[j-1];
				zero_d[j] <= zero_d[j-1];
			end
			s_s2    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			s_s3    <= sh3;
			k_s3    <= k3;
			done_s3 <= done3;
			s_s4    <= sh4;
			k_d[NRM_SQ_IN] <= k4;
			for (int j = NRM_SQ_IN + 1; j <= NRM_SQ_OUT; j++) begin
				k_d[j] <= k_d[j-1];
			end
			// dividend |a| << (16 + k), bounded by len << 16
			for (int i = 0; i < 3; i++) begin
				num_s37[i] <= DIV_NUM_W'(mag_d[NRM_SQ_OUT][i]) << (6'd16 + 6'(k_d[NRM_SQ_OUT]));
			end
			len_s37 <= len;
			nz_d[NRM_DIV_IN] <= {neg_d[NRM_SQ_OUT], zero_d[NRM_SQ_OUT]};
			for (int j = NRM_DIV_IN + 1; j <= NRM_DIV_OUT; j++) begin
				nz_d[j] <= nz_d[j-1];
			end
			for (int i = 0; i < 3; i++) begin
				if (nz_d[NRM_DIV_OUT][0]) begin
					unit[i] <= '0;
				end else if (nz_d[NRM_DIV_OUT][i+1]) begin
					unit[i] <= 18'(-{1'b0, quo[i]});
				end else begin
					unit[i] <= {1'b0, quo[i]};
				end
			end
			zero <= nz_d[NRM_DIV_OUT][0];
		end
	end

	v3o_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (s_s4),
		.root (len)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3o_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s37[i]),
			.den (len_s37),
			.quo (quo[i])
		);
	end

endmodule

// ===== src/v3o_front.sv =====
// ----------------------------------------------------------------------------
// v3o_front: input side of the unit
// Accepts transactions, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
module v3o_front import v3o_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  cmd_t  cmd,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	item_t          ent_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           wr;
	item_t          cls;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = ent_q[rp_q];
	assign wr      = push && !full;

	always_comb begin
		cls.op = op_t'(cmd.action);
		cls.ax = cmd.ax;
		cls.ay = cmd.ay;
		cls.az = cmd.az;
		cls.bx = cmd.bx;
		cls.by = cmd.by;
		cls.bz = cmd.bz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= cls;
		end
	end

`ifndef ASSERT_OFF
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != '0)
		else $error("front queue popped while empty");
`endif

endmodule

// ===== src/v3o_back.sv =====
// ----------------------------------------------------------------------------
// v3o_back: execution pipeline of the unit
// All operations run down one stalling pipeline so results leave in order.
// ----------------------------------------------------------------------------
module v3o_back import v3o_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  empty,
	input  logic  pop,
	output rsp_t  rsp
);

	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] r;
		logic             ov;
	} head_t;

	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] r;
		logic             ov;
		logic             fz;
		logic             fpi;
		logic             cneg;
	} tail_t;

	function automatic logic [32:0] sat32(input logic signed [64:0] v);
		logic signed [64:0] hi, lo;
		hi = 65'sd2147483647;
		lo = -65'sd2147483648;
		if (v > hi) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (v < lo) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	logic [LAST:0] v_q;
	logic          adv;
	item_t         it_s0;

	logic signed [31:0] a [3];
	logic signed [31:0] b [3];
	logic signed [63:0] prod_s1 [6];
	logic [32:0]        off_s1 [3];
	op_t                op_s1;
	logic [32:0]        crs [3];

	head_t head_q [2:NORM_LAT];
	tail_t tail_q [ANG_DOT:ANG_CORD];

	logic [2:0][17:0]   ua, ub;
	logic               za, zb;
	logic signed [35:0] dp_s56 [3];
	logic signed [37:0] c_s57;
	logic [37:0]        absc;
	logic [29:0]        m_s58;
	logic [59:0]        x2_s58;
	logic [63:0]        arg_s59;
	logic [29:0]        m_d [ANG_ARG:ANG_SQRT];
	logic [31:0]        yroot;
	logic signed [CORDIC_W-1:0] zang;

	logic signed [34:0] zc;
	logic [20:0]        rnd;
	logic [17:0]        ang;
	rsp_t               rsp_q;
	op_t                op_s116;

	// whole pipeline moves unless a finished result is waiting and not popped
	assign adv   = !v_q[LAST] || pop;
	assign q_pop = adv && q_valid;
	assign empty = !v_q[LAST];
	assign rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAST-1:0], q_valid};
		end
	end

	assign a[0] = it_s0.ax;
	assign a[1] = it_s0.ay;
	assign a[2] = it_s0.az;
	assign b[0] = it_s0.bx;
	assign b[1] = it_s0.by;
	assign b[2] = it_s0.bz;

	// cross term: floor((p1 - p2) / 2^16), saturated
	for (genvar i = 0; i < 3; i++) begin : g_crs
		logic signed [64:0] diff;
		assign diff   = 65'(prod_s1[2*i]) - 65'(prod_s1[2*i+1]);
		assign crs[i] = sat32(diff >>> 16);
	end

	assign absc = c_s57[37] ? 38'(-c_s57) : 38'(c_s57);

	always_comb begin
		zc = (zang < 0) ? '0 : 35'(zang);
		if (tail_q[ANG_CORD].cneg) begin
			zc = PI_Q30 - zc;
		end
		if (zc < 0) begin
			zc = '0;
		end
		rnd = 21'((zc + 35'sd8192) >>> 14);
		ang = (rnd > 21'(PI_Q16)) ? PI_Q16 : rnd[17:0];
		if (tail_q[ANG_CORD].op != OP_ANGLE || tail_q[ANG_CORD].fz) begin
			ang = '0;
		end else if (tail_q[ANG_CORD].fpi) begin
			ang = PI_Q16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s0 <= q_item;

			// stage 1: products and offset sums
			op_s1 <= it_s0.op;
			prod_s1[0] <= a[1] * b[2];
			prod_s1[1] <= a[2] * b[1];
			prod_s1[2] <= a[2] * b[0];
			prod_s1[3] <= a[0] * b[2];
			prod_s1[4] <= a[0] * b[1];
			prod_s1[5] <= a[1] * b[0];
			for (int i = 0; i < 3; i++) begin
				off_s1[i] <= sat32(65'(a[i]) + 65'(b[i]));
			end

			// stage 2: select the short result
			head_q[2].op <= op_s1;
			case (op_s1)
				OP_OFFSET: begin
					head_q[2].r  <= {off_s1[2][31:0], off_s1[1][31:0], off_s1[0][31:0]};
					head_q[2].ov <= off_s1[0][32] | off_s1[1][32] | off_s1[2][32];
				end
				OP_CROSS: begin
					head_q[2].r  <= {crs[2][31:0], crs[1][31:0], crs[0][31:0]};
					head_q[2].ov <= crs[0][32] | crs[1][32] | crs[2][32];
				end
				default: begin
					head_q[2].r  <= '0;
					head_q[2].ov <= 1'b0;
				end
			endcase
			for (int j = 3; j <= NORM_LAT; j++) begin
				head_q[j] <= head_q[j-1];
			end

			// join with the unit vectors
			tail_q[ANG_DOT].op   <= head_q[NORM_LAT].op;
			tail_q[ANG_DOT].ov   <= head_q[NORM_LAT].ov;
			tail_q[ANG_DOT].fz   <= za | zb;
			tail_q[ANG_DOT].fpi  <= 1'b0;
			tail_q[ANG_DOT].cneg <= 1'b0;
			if (head_q[NORM_LAT].op == OP_NORM) begin
				for (int i = 0; i < 3; i++) begin
					tail_q[ANG_DOT].r[i] <= 32'($signed(ua[i]));
				end
			end else begin
				tail_q[ANG_DOT].r <= head_q[NORM_LAT].r;
			end
			for (int j = ANG_DOT + 1; j <= ANG_CORD; j++) begin
				if (j != ANG_CLS) begin
					tail_q[j] <= tail_q[j-1];
				end
			end
			// cosine classification joins the tail here
			tail_q[ANG_CLS].op   <= tail_q[ANG_SUM].op;
			tail_q[ANG_CLS].r    <= tail_q[ANG_SUM].r;
			tail_q[ANG_CLS].ov   <= tail_q[ANG_SUM].ov;
			tail_q[ANG_CLS].fz   <= tail_q[ANG_SUM].fz || (c_s57 >= 38'sd4294967296);
			tail_q[ANG_CLS].fpi  <= (c_s57 <= -38'sd4294967296);
			tail_q[ANG_CLS].cneg <= c_s57[37];

			// angle path
			for (int i = 0; i < 3; i++) begin
				dp_s56[i] <= $signed(ua[i]) * $signed(ub[i]);
			end
			c_s57   <= 38'(dp_s56[0]) + 38'(dp_s56[1]) + 38'(dp_s56[2]);
			m_s58   <= absc[31:2];
			x2_s58  <= absc[31:2] * absc[31:2];
			arg_s59 <= 64'h1000_0000_0000_0000 - 64'(x2_s58);
			m_d[ANG_ARG] <= m_s58;
			for (int j = ANG_ARG + 1; j <= ANG_SQRT; j++) begin
				m_d[j] <= m_d[j-1];
			end

			// result register
			op_s116        <= tail_q[ANG_CORD].op;
			rsp_q.rx       <= tail_q[ANG_CORD].r[0];
			rsp_q.ry       <= tail_q[ANG_CORD].r[1];
			rsp_q.rz       <= tail_q[ANG_CORD].r[2];
			rsp_q.overflow <= tail_q[ANG_CORD].ov;
			rsp_q.angle    <= ang;
		end
	end

	v3o_norm u_norm_a (
		.clk  (clk),
		.en   (adv),
		.vec  ({it_s0.az, it_s0.ay, it_s0.ax}),
		.unit (ua),
		.zero (za)
	);

	v3o_norm u_norm_b (
		.clk  (clk),
		.en   (adv),
		.vec  ({it_s0.bz, it_s0.by, it_s0.bx}),
		.unit (ub),
		.zero (zb)
	);

	v3o_sqrt u_sqrt_y (
		.clk  (clk),
		.en   (adv),
		.rad  (arg_s59),
		.root (yroot)
	);

	v3o_cordic u_cordic (
		.clk (clk),
		.en  (adv),
		.x0  (m_d[ANG_SQRT]),
		.y0  (yroot),
		.z   (zang)
	);

`ifndef ASSERT_OFF
	a_ov_only_arith: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[LAST] && (op_s116 == OP_NORM || op_s116 == OP_ANGLE) |-> !rsp_q.overflow)
		else $error("overflow flagged on normalize or angle");
`endif

`ifndef ASSERT_OFF
	a_angle_only_angle: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[LAST] && op_s116 != OP_ANGLE |-> rsp_q.angle == '0)
		else $error("angle field set on a vector operation");
`endif

`ifndef ASSERT_OFF
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[LAST] && op_s116 == OP_ANGLE |-> rsp_q.angle <= PI_Q16
			&& rsp_q.rx == '0 && rsp_q.ry == '0 && rsp_q.rz == '0)
		else $error("angle result out of range or vector not cleared");
`endif

endmodule

// ===== src/vector3_ops_unit_core.sv =====
// ----------------------------------------------------------------------------
// vector3_ops_unit_core: 3D vector arithmetic unit, signed Q16.16
// Normalize, offset add, cross product and angle between two vectors.
// ----------------------------------------------------------------------------
// One result transaction comes back for every accepted command, in order.
// The unit takes one command per clock and returns one result per clock when
// the consumer keeps popping; a result takes the same route through the unit
// whatever the action, because every action rides the same stalling
// pipeline. Its depth is set by the angle path: two unit vector lanes
// (32-stage square root plus 17-stage divider each), the dot product, a
// second 32-stage square root for the sine term and 24 CORDIC steps. A
// four-entry command queue in front decouples the push side from the
// pipeline; the pipeline freezes only while a finished result is waiting and
// not popped, and the queue keeps taking commands until it fills. Offset and
// cross results that leave the int32 range saturate and set overflow;
// normalize of a zero vector returns zero, and the angle is 0 when either
// vector has zero length.
module vector3_ops_unit_core import v3o_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	// command side
	input  logic push,
	output logic full,
	input  cmd_t cmd,
	// result side
	output logic empty,
	input  logic pop,
	output rsp_t rsp
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// accept, decode, queue
	v3o_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// execute; owns the result register
	v3o_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

// ===== tb/sv/vector3_ops_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// vector3_ops_unit_core_tb: self-checking bench for the 3D vector unit
// Drives command transactions through the push side and checks every popped
// result against a bit-exact fixed-point predictor. It covers every action,
// field extremes, zero vectors and parallel or opposite vectors, under
// several push and pop idling mixes.
// ----------------------------------------------------------------------------
module vector3_ops_unit_core_tb;
	import v3o_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 450;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 200; // pipeline is 117 deep plus queue

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	cmd_t cmd;
	logic empty;
	logic pop;
	rsp_t rsp;

	vector3_ops_unit_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.rsp(rsp)
	);

	cmd_t  cmd_backlog [$];  // commands waiting to be pushed
	rsp_t  rsp_expected [$]; // predicted results, oldest first
	int    push_idle_pct;
	int    pop_stall_pct;
	bit    cmd_taken;
	int    errors;
	int    cycles;

	// ------------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------------

	// floor(sqrt(v)), bit-serial
	function automatic bit [63:0] isqrt(bit [63:0] v);
		bit [63:0] r;
		bit [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit [63:0] magnitude(longint v);
		return (v < 0) ? bit'(1) ? 64'(-v) : 64'(v) : 64'(v);
	endfunction

	// scale v to unit length in Q16.16, truncating toward zero;
	// returns 0 when v is the zero vector
	function automatic bit unit_vector(input longint v [3], output longint u [3]);
		bit [63:0] sumsq;
		bit [63:0] len;
		bit [63:0] q;
		int        k;
		sumsq = 0;
		k = 0;
		for (int i = 0; i < 3; i++)
			sumsq += magnitude(v[i]) * magnitude(v[i]);
		for (int i = 0; i < 3; i++)
			u[i] = 0;
		if (sumsq == 0)
			return 0;
		while (k < 16 && sumsq < (64'd1 << 62)) begin
			sumsq = sumsq << 2;
			k++;
		end
		len = isqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = (magnitude(v[i]) << (16 + k)) / len;
			u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint saturate(longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// floor((p1 - p2) / 2^16) without a 64-bit overflow on the difference
	function automatic longint cross_term(longint p1, longint p2);
		longint h1;
		longint h2;
		longint l1;
		longint l2;
		h1 = p1 >>> 16;
		h2 = p2 >>> 16;
		l1 = p1 - h1 * 65536;
		l2 = p2 - h2 * 65536;
		return h1 - h2 - ((l1 < l2) ? 1 : 0);
	endfunction

	function automatic logic [17:0] angle_between(input longint a [3], input longint b [3]);
		longint    ua [3];
		longint    ub [3];
		longint    c;
		longint    x;
		longint    y;
		longint    z;
		longint    dx;
		longint    dy;
		bit [63:0] m;
		bit [63:0] res;
		if (!unit_vector(a, ua) || !unit_vector(b, ub))
			return '0;
		c = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
		if (c >= 64'sh100000000)
			return '0;
		if (c <= -64'sh100000000)
			return PI_Q16;
		m = magnitude(c) >> 2;
		x = longint'(m);
		y = longint'(isqrt((64'd1 << 60) - m * m));
		z = 0;
		// CORDIC vectoring: drive y to zero, accumulate the rotation
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx;
				y += dy;
				z -= longint'(ATAN_TAB[i]);
			end
		end
		if (z < 0)
			z = 0;
		if (c < 0)
			z = longint'(PI_Q30) - z;
		if (z < 0)
			z = 0;
		res = (64'(z) + 64'd8192) >> 14;
		return (res > 64'(PI_Q16)) ? PI_Q16 : res[17:0];
	endfunction

	function automatic rsp_t vector_result(cmd_t c);
		rsp_t   r;
		longint a [3];
		longint b [3];
		longint v [3];
		bit     ovf;
		a = '{longint'(c.ax), longint'(c.ay), longint'(c.az)};
		b = '{longint'(c.bx), longint'(c.by), longint'(c.bz)};
		v = '{0, 0, 0};
		ovf = 0;
		r = '0;
		case (op_t'(c.action))
			OP_NORM: begin
				// zero vector passes through unchanged
				if (!unit_vector(a, v))
					v = a;
			end
			OP_OFFSET: begin
				for (int i = 0; i < 3; i++)
					v[i] = saturate(a[i] + b[i], ovf);
			end
			OP_CROSS: begin
				v[0] = saturate(cross_term(a[1] * b[2], a[2] * b[1]), ovf);
				v[1] = saturate(cross_term(a[2] * b[0], a[0] * b[2]), ovf);
				v[2] = saturate(cross_term(a[0] * b[1], a[1] * b[0]), ovf);
			end
			default: begin
				r.angle = angle_between(a, b);
			end
		endcase
		r.rx = v[0][31:0];
		r.ry = v[1][31:0];
		r.rz = v[2][31:0];
		r.overflow = ovf;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// component drawn from a mix of ranges so saturation, tiny lengths and
	// full-scale values all show up
	function automatic logic [31:0] rand_component();
		case ($urandom_range(7))
			0, 1:    return $urandom;
			2:       return 32'($signed($urandom_range(32'h00200000)) - 32'sh00100000);
			3:       return 32'($signed($urandom_range(16)) - 8);
			4:       return '0;
			5:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(32'h01000000)) - 32'sh00800000);
		endcase
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.action = 2'($urandom_range(3));
		c.ax = rand_component();
		c.ay = rand_component();
		c.az = rand_component();
		c.bx = rand_component();
		c.by = rand_component();
		c.bz = rand_component();
		// parallel and opposite vectors hit the cosine clamp
		case ($urandom_range(9))
			0: {c.bx, c.by, c.bz} = {c.ax, c.ay, c.az};
			1: {c.bx, c.by, c.bz} = {-c.ax, -c.ay, -c.az};
			default: ;
		endcase
		return c;
	endfunction

	function automatic cmd_t make_cmd(op_t op, logic [31:0] ax, logic [31:0] ay,
			logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		cmd_t c;
		c.action = op;
		{c.ax, c.ay, c.az, c.bx, c.by, c.bz} = {ax, ay, az, bx, by, bz};
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Clock, driver and monitor
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// a command is taken when push is high and full is low at the edge;
	// the prediction is queued at that same edge
	always @(posedge clk) begin
		cmd_taken = arst_n && push && !full;
		if (cmd_taken)
			rsp_expected.push_back(vector_result(cmd));
	end

	// driver: inputs move on the falling edge only
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken)
				void'(cmd_backlog.pop_front());
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= push_idle_pct) begin
				push <= 1'b1;
				cmd  <= cmd_backlog[0];
			end else begin
				push <= 1'b0;
			end
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// monitor: compare each popped transaction with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && pop && !empty) begin
			if (rsp_expected.size() == 0) begin
				$display("%0t: unexpected result rx=%h ry=%h rz=%h angle=%0d overflow=%b",
					$time, rsp.rx, rsp.ry, rsp.rz, rsp.angle, rsp.overflow);
				errors++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp.rx !== want.rx) begin
					$display("%0t: rx expected %h actual %h", $time, want.rx, rsp.rx);
					errors++;
				end
				if (rsp.ry !== want.ry) begin
					$display("%0t: ry expected %h actual %h", $time, want.ry, rsp.ry);
					errors++;
				end
				if (rsp.rz !== want.rz) begin
					$display("%0t: rz expected %h actual %h", $time, want.rz, rsp.rz);
					errors++;
				end
				if (rsp.angle !== want.angle) begin
					$display("%0t: angle expected %0d actual %0d", $time, want.angle,
						rsp.angle);
					errors++;
				end
				if (rsp.overflow !== want.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, want.overflow,
						rsp.overflow);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		errors = 0;
		cycles = 0;
		cmd_taken = 0;
		push_idle_pct = 0;
		pop_stall_pct = 0;
		push = 1'b0;
		pop  = 1'b0;
		cmd  = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, each action, zero and clamp cases
		cmd_backlog.push_back(make_cmd(OP_NORM, 0, 0, 0, 1, 2, 3));
		cmd_backlog.push_back(make_cmd(OP_NORM, 32'h00010000, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_NORM, 32'h80000000, 32'h80000000,
			32'h80000000, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_NORM, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_NORM, 1, 0, 32'hffffffff, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_OFFSET, 32'h7fffffff, 32'h80000000, 5,
			1, 32'hffffffff, 32'hfffffffb));
		cmd_backlog.push_back(make_cmd(OP_OFFSET, 32'h7fffffff, 32'h80000000,
			32'hffffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff));
		cmd_backlog.push_back(make_cmd(OP_CROSS, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
		cmd_backlog.push_back(make_cmd(OP_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0));
		cmd_backlog.push_back(make_cmd(OP_CROSS, 32'hffffffff, 3, 32'hfffffffe,
			7, 32'hfffffffb, 1));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 0, 0, 0, 1, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 1, 0, 0, 0, 0, 0));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 32'h00030000, 32'h00040000, 0,
			32'h00030000, 32'h00040000, 0));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 32'h00030000, 32'h00040000, 0,
			32'hfffd0000, 32'hfffc0000, 0));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 32'h00010000, 0, 0, 0, 32'h00010000, 0));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 32'h80000000, 32'h80000000,
			32'h80000000, 1, 1, 1));
		cmd_backlog.push_back(make_cmd(OP_ANGLE, 1, 2, 3, 32'h7fffffff, 32'h7fffffff,
			32'h7ffffffe));
		wait (cmd_backlog.size() == 0 && rsp_expected.size() == 0);

		// random phases: free running, slow producer, slow consumer, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin push_idle_pct = 85; pop_stall_pct = 0;  end
				2: begin push_idle_pct = 0;  pop_stall_pct = 85; end
				default: begin push_idle_pct = 15; pop_stall_pct = 15; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				cmd_backlog.push_back(rand_cmd());
			wait (cmd_backlog.size() == 0 && rsp_expected.size() == 0);
		end

		// let any stray result surface
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
